// ----- hdl/b3c_pkg.sv -----
// Shared types, constants and compression functions for the BLAKE3 chunk engine.
package b3c_pkg;

   localparam int MAX_BLOCKS  = 16;
   localparam int BLK_W       = 5;
   localparam int ROUNDS      = 7;
   localparam int RND_W       = 3;
   localparam int CSR_IDX_W   = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_0_1   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_2_3   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_4_5   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_6_7   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_CTR = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CTR_INC   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FLAGS     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKS    = 3'd7;

   localparam logic [31:0] IV0 = 32'h6A09E667;
   localparam logic [31:0] IV1 = 32'hBB67AE85;
   localparam logic [31:0] IV2 = 32'h3C6EF372;
   localparam logic [31:0] IV3 = 32'hA54FF53A;
   localparam logic [31:0] BLOCK_LEN = 32'd64;

   typedef logic [15:0][31:0] words16_type;
   typedef logic [7:0][31:0]  cv_type;
   typedef logic [7:0][63:0]  msg_in_type;

   typedef struct packed {
      logic [63:0]      start_counter;
      logic             counter_increments;
      logic [23:0]      flag_bits;
      logic [BLK_W-1:0] blocks_per_input;
   } cfg_type;

   typedef struct packed {
      words16_type msg;
      logic [63:0] ctr;
      logic [7:0]  flags;
      logic        first;
      logic        last;
   } entry_type;

   function automatic logic [3:0][31:0] mix(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d,
                                            input logic [31:0] x, input logic [31:0] y);
      logic [31:0] ta, tb, tc, td;
      logic [3:0][31:0] r;
      ta = a + b + x;
      td = d ^ ta;  td = {td[15:0], td[31:16]};
      tc = c + td;
      tb = b ^ tc;  tb = {tb[11:0], tb[31:12]};
      ta = ta + tb + y;
      td = td ^ ta; td = {td[7:0], td[31:8]};
      tc = tc + td;
      tb = tb ^ tc; tb = {tb[6:0], tb[31:7]};
      r[0] = ta; r[1] = tb; r[2] = tc; r[3] = td;
      return r;
   endfunction

   function automatic words16_type compress_round(input words16_type s,
                                                  input words16_type m);
      words16_type t;
      logic [3:0][31:0] r;
      t = s;
      for (int i = 0; i < 4; i++) begin
         r = mix(t[i], t[4+i], t[8+i], t[12+i], m[2*i], m[2*i+1]);
         t[i] = r[0]; t[4+i] = r[1]; t[8+i] = r[2]; t[12+i] = r[3];
      end
      r = mix(t[0], t[5], t[10], t[15], m[8], m[9]);
      t[0] = r[0]; t[5] = r[1]; t[10] = r[2]; t[15] = r[3];
      r = mix(t[1], t[6], t[11], t[12], m[10], m[11]);
      t[1] = r[0]; t[6] = r[1]; t[11] = r[2]; t[12] = r[3];
      r = mix(t[2], t[7], t[8], t[13], m[12], m[13]);
      t[2] = r[0]; t[7] = r[1]; t[8] = r[2]; t[13] = r[3];
      r = mix(t[3], t[4], t[9], t[14], m[14], m[15]);
      t[3] = r[0]; t[4] = r[1]; t[9] = r[2]; t[14] = r[3];
      return t;
   endfunction

   // message word order for the next round
   function automatic words16_type permute(input words16_type m);
      words16_type p;
      p[0]  = m[2];  p[1]  = m[6];  p[2]  = m[3];  p[3]  = m[10];
      p[4]  = m[7];  p[5]  = m[0];  p[6]  = m[4];  p[7]  = m[13];
      p[8]  = m[1];  p[9]  = m[11]; p[10] = m[12]; p[11] = m[5];
      p[12] = m[9];  p[13] = m[14]; p[14] = m[15]; p[15] = m[8];
      return p;
   endfunction

   function automatic cv_type fold(input words16_type s);
      cv_type c;
      for (int i = 0; i < 8; i++) begin
         c[i] = s[i] ^ s[i+8];
      end
      return c;
   endfunction

endpackage

// ----- hdl/b3c_fifo.sv -----
// Two-entry queue of classified blocks between front end and compression core.
module b3c_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b3c_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output b3c_pkg::entry_type  head
);

   b3c_pkg::entry_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/b3c_front.sv -----
// Front end: accepts message blocks and tags them with counter, flags and position.
module b3c_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  b3c_pkg::msg_in_type  req_msg,
   input  b3c_pkg::cfg_type     cfg,
   input  logic                 q_full,
   output logic                 q_push,
   output b3c_pkg::entry_type   q_entry
);

   logic [b3c_pkg::BLK_W-1:0] block_index_ff, block_index_in;
   logic [63:0]               input_counter_ff, input_counter_in;
   logic [b3c_pkg::BLK_W-1:0] nblk;
   logic [b3c_pkg::BLK_W:0]   next_idx;
   logic                      first, last;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      // clamp the block count to 1..MAX_BLOCKS
      if (cfg.blocks_per_input == '0) begin
         nblk = b3c_pkg::BLK_W'(1);
      end else if (cfg.blocks_per_input > b3c_pkg::BLK_W'(b3c_pkg::MAX_BLOCKS)) begin
         nblk = b3c_pkg::BLK_W'(b3c_pkg::MAX_BLOCKS);
      end else begin
         nblk = cfg.blocks_per_input;
      end
      next_idx = {1'b0, block_index_ff} + 1'b1;
      first    = (block_index_ff == '0);
      last     = (next_idx >= {1'b0, nblk});

      for (int i = 0; i < 8; i++) begin
         q_entry.msg[2*i]   = req_msg[i][31:0];
         q_entry.msg[2*i+1] = req_msg[i][63:32];
      end
      q_entry.ctr   = cfg.start_counter + (cfg.counter_increments ? input_counter_ff : 64'd0);
      q_entry.flags = cfg.flag_bits[7:0] | (first ? cfg.flag_bits[15:8] : 8'd0)
                      | (last ? cfg.flag_bits[23:16] : 8'd0);
      q_entry.first = first;
      q_entry.last  = last;

      block_index_in   = block_index_ff;
      input_counter_in = input_counter_ff;
      if (q_push) begin
         if (last) begin
            block_index_in   = '0;
            input_counter_in = input_counter_ff + 64'd1;
         end else begin
            block_index_in = next_idx[b3c_pkg::BLK_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_index_ff   <= '0;
         input_counter_ff <= '0;
      end else begin
         block_index_ff   <= block_index_in;
         input_counter_ff <= input_counter_in;
      end
   end

endmodule

// ----- hdl/b3c_core.sv -----
// Compression core: one round per cycle (last may hold), CV kept, result reg.
module b3c_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  b3c_pkg::entry_type  q_head,
   output logic                q_pop,
   input  b3c_pkg::cv_type     key,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output b3c_pkg::cv_type     rsp_cv
);

   logic                      busy_ff, busy_in;
   logic [b3c_pkg::RND_W-1:0] round_ff, round_in;
   logic                      last_ff, last_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   b3c_pkg::words16_type      st_ff, st_in, msg_ff, msg_in, nxt;
   b3c_pkg::cv_type           cv_ff, cv_in, rsp_cv_ff, rsp_cv_in, cv_start, folded;
   logic                      final_round, finish;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cv    = rsp_cv_ff;
   assign q_pop     = !busy_ff && q_valid;

   always_comb begin
      nxt         = b3c_pkg::compress_round(st_ff, msg_ff);
      folded      = b3c_pkg::fold(nxt);
      final_round = busy_ff && (round_ff == b3c_pkg::RND_W'(b3c_pkg::ROUNDS - 1));
      // a final block holds in its last round while a previous result waits
      finish      = final_round && (!last_ff || !rsp_valid_ff || rsp_ready);
      cv_start    = q_head.first ? key : cv_ff;

      busy_in      = busy_ff;
      round_in     = round_ff;
      last_in      = last_ff;
      st_in        = st_ff;
      msg_in       = msg_ff;
      cv_in        = cv_ff;
      rsp_cv_in    = rsp_cv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (q_pop) begin
         busy_in  = 1'b1;
         round_in = '0;
         last_in  = q_head.last;
         msg_in   = q_head.msg;
         for (int i = 0; i < 8; i++) begin
            st_in[i] = cv_start[i];
         end
         st_in[8]  = b3c_pkg::IV0;
         st_in[9]  = b3c_pkg::IV1;
         st_in[10] = b3c_pkg::IV2;
         st_in[11] = b3c_pkg::IV3;
         st_in[12] = q_head.ctr[31:0];
         st_in[13] = q_head.ctr[63:32];
         st_in[14] = b3c_pkg::BLOCK_LEN;
         st_in[15] = {24'd0, q_head.flags};
      end else if (busy_ff && !final_round) begin
         st_in    = nxt;
         msg_in   = b3c_pkg::permute(msg_ff);
         round_in = round_ff + 1'b1;
      end else if (finish) begin
         busy_in = 1'b0;
         cv_in   = folded;
         if (last_ff) begin
            rsp_cv_in    = folded;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      st_ff     <= st_in;
      msg_ff    <= msg_in;
      cv_ff     <= cv_in;
      rsp_cv_ff <= rsp_cv_in;
      last_ff   <= last_in;
      round_ff  <= round_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- hdl/blake3_chunk_chaining_hash_top.sv -----
// Top level of the BLAKE3 chunk chaining-value engine.
//
//   channel | prefix | handshake           | payload
//   --------+--------+---------------------+----------------------------------
//   input   | req_   | req_valid/req_ready | msg_words_0_1 .. msg_words_14_15
//   result  | rsp_   | rsp_valid/rsp_ready | cv_words_0_1 .. cv_words_6_7
//   config  | csr_   | csr_write_enable    | csr_index, csr_write_data
//
// In the compression core each block loads the state, then runs seven rounds,
// one per cycle through a single round unit; only the last round can hold.
// Front end and two-entry queue accept blocks while the core works, until full.
// A finished chaining value waits in the result register; the core holds in its
// last round only if another result is ready while that one is not taken.
// Reset is synchronous and clears control state; configuration returns to defaults.
module blake3_chunk_chaining_hash_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [63:0]                     req_msg_words_0_1,
   input  logic [63:0]                     req_msg_words_2_3,
   input  logic [63:0]                     req_msg_words_4_5,
   input  logic [63:0]                     req_msg_words_6_7,
   input  logic [63:0]                     req_msg_words_8_9,
   input  logic [63:0]                     req_msg_words_10_11,
   input  logic [63:0]                     req_msg_words_12_13,
   input  logic [63:0]                     req_msg_words_14_15,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [63:0]                     rsp_cv_words_0_1,
   output logic [63:0]                     rsp_cv_words_2_3,
   output logic [63:0]                     rsp_cv_words_4_5,
   output logic [63:0]                     rsp_cv_words_6_7,
   input  logic                            csr_write_enable,
   input  logic [b3c_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [63:0]                     csr_write_data
);

   logic [3:0][63:0]     key_ff, key_in;
   b3c_pkg::cfg_type     cfg_ff, cfg_in;
   b3c_pkg::msg_in_type  req_msg;
   b3c_pkg::entry_type   push_entry, head;
   b3c_pkg::cv_type      key_words, cv;
   logic                 push, full, pop, not_empty;

   assign req_msg[0] = req_msg_words_0_1;
   assign req_msg[1] = req_msg_words_2_3;
   assign req_msg[2] = req_msg_words_4_5;
   assign req_msg[3] = req_msg_words_6_7;
   assign req_msg[4] = req_msg_words_8_9;
   assign req_msg[5] = req_msg_words_10_11;
   assign req_msg[6] = req_msg_words_12_13;
   assign req_msg[7] = req_msg_words_14_15;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         key_words[2*i]   = key_ff[i][31:0];
         key_words[2*i+1] = key_ff[i][63:32];
      end
   end

   assign rsp_cv_words_0_1 = {cv[1], cv[0]};
   assign rsp_cv_words_2_3 = {cv[3], cv[2]};
   assign rsp_cv_words_4_5 = {cv[5], cv[4]};
   assign rsp_cv_words_6_7 = {cv[7], cv[6]};

   always_comb begin
      key_in = key_ff;
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            b3c_pkg::CSR_KEY_0_1:   key_in[0] = csr_write_data;
            b3c_pkg::CSR_KEY_2_3:   key_in[1] = csr_write_data;
            b3c_pkg::CSR_KEY_4_5:   key_in[2] = csr_write_data;
            b3c_pkg::CSR_KEY_6_7:   key_in[3] = csr_write_data;
            b3c_pkg::CSR_START_CTR: cfg_in.start_counter = csr_write_data;
            b3c_pkg::CSR_CTR_INC:   cfg_in.counter_increments = csr_write_data[0];
            b3c_pkg::CSR_FLAGS:     cfg_in.flag_bits = csr_write_data[23:0];
            b3c_pkg::CSR_BLOCKS:
               cfg_in.blocks_per_input = csr_write_data[b3c_pkg::BLK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff                    <= '0;
         cfg_ff.start_counter      <= '0;
         cfg_ff.counter_increments <= 1'b1;
         cfg_ff.flag_bits          <= '0;
         cfg_ff.blocks_per_input   <= b3c_pkg::BLK_W'(b3c_pkg::MAX_BLOCKS);
      end else begin
         key_ff <= key_in;
         cfg_ff <= cfg_in;
      end
   end

   b3c_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_msg   (req_msg),
      .cfg       (cfg_ff),
      .q_full    (full),
      .q_push    (push),
      .q_entry   (push_entry)
   );

   b3c_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .not_empty  (not_empty),
      .head       (head)
   );

   b3c_core u_core (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (not_empty),
      .q_head    (head),
      .q_pop     (pop),
      .key       (key_words),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_cv    (cv)
   );

endmodule

// ----- hdl/b3c_checker.sv -----
// Port-level checks for the BLAKE3 chunk engine, bound to the top level.
module b3c_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_cv_words_0_1,
   input logic [63:0] rsp_cv_words_6_7
);

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready right after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cv_words_0_1)
                                 && $stable(rsp_cv_words_6_7))
      else $error("stalled result changed");

endmodule

bind blake3_chunk_chaining_hash_top b3c_checker u_b3c_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_cv_words_0_1 (rsp_cv_words_0_1),
   .rsp_cv_words_6_7 (rsp_cv_words_6_7)
);
